### hw/rtl/dcmp_pkg.sv
package dcmp_pkg;

  localparam int unsigned PosBitsDef = 32;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned AddrBits   = 4;

  localparam logic [15:0] StepIntervalRst  = 16'd1000;
  localparam logic [15:0] BacklashStepsRst = 16'd300;
  localparam logic        BacklashEnRst    = 1'b1;
  localparam logic [7:0]  SpeedRst         = 8'd255;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_TARGET  = 2'd1,
    MODE_CURRENT = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_STEP_INTERVAL  = 2'd0,
    REG_BACKLASH_STEPS = 2'd1,
    REG_BACKLASH_EN    = 2'd2,
    REG_SPEED          = 2'd3
  } reg_e;

  typedef struct packed {
    logic        drive_a;
    logic        drive_b;
    logic        drive_on;
    logic [7:0]  duty;
    logic [31:0] position;
    logic        stepped;
    logic        compensating;
  } res_t;

endpackage

### hw/rtl/dcmp_ifs.sv
interface dcmp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dcmp_out_if;
  logic               valid;
  logic               ready;
  logic               drive_a;
  logic               drive_b;
  logic               drive_on;
  logic [7:0]         duty;
  logic signed [31:0] position;
  logic               stepped;
  logic               compensating;

  modport source (output valid, output drive_a, output drive_b, output drive_on,
                  output duty, output position, output stepped, output compensating,
                  input ready);
  modport sink   (input valid, input drive_a, input drive_b, input drive_on,
                  input duty, input position, input stepped, input compensating,
                  output ready);
endinterface

### hw/rtl/dc_motor_position_stepper_backlash.sv
// A word's result is registered in the output register, or in the skid register while the output word is held.
// Throughput: one word per cycle; the position, target and interval state is updated
// in a single pass at the accepting edge, and a skid stage keeps input open while a
// result waits. Input stalls only when both output and skid registers are full.
// Reset (rst_ni low, asynchronous): positions, counters and bridge levels clear,
// registers take step_interval 1000, backlash_steps 300, backlash_enable 1, speed 255.
module dc_motor_position_stepper_backlash #(
  parameter int unsigned POSITION_BITS = dcmp_pkg::PosBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dcmp_in_if.sink                       in_i,
  dcmp_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcmp_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned WideBits = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  logic [15:0] step_interval_q;
  logic [15:0] backlash_steps_q;
  logic        backlash_en_q;
  logic [7:0]  speed_q;

  logic signed [POSITION_BITS-1:0] cur_q, cur_d;
  logic signed [POSITION_BITS-1:0] tgt_q, tgt_d;
  logic        last_ccw_q, last_ccw_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] bl_left_q, bl_left_d;
  logic [2:0]  bridge_q, bridge_d;
  logic [7:0]  duty_q, duty_d;

  dcmp_pkg::res_t res;
  dcmp_pkg::res_t out_q;
  dcmp_pkg::res_t skid_q;
  logic           out_v_q;
  logic           skid_v_q;

  logic                      accept;
  logic                      out_take;
  logic                      cfg_wr;
  dcmp_pkg::reg_e            reg_sel;
  logic signed [WideBits-1:0] val_wide;
  logic signed [WideBits-1:0] pos_wide;
  logic [15:0]               el_inc;
  logic                      ccw;
  logic                      do_step;
  logic                      stepped;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = dcmp_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      dcmp_pkg::REG_STEP_INTERVAL:  prdata = {16'd0, step_interval_q};
      dcmp_pkg::REG_BACKLASH_STEPS: prdata = {16'd0, backlash_steps_q};
      dcmp_pkg::REG_BACKLASH_EN:    prdata = {31'd0, backlash_en_q};
      dcmp_pkg::REG_SPEED:          prdata = {24'd0, speed_q};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_interval_q  <= dcmp_pkg::StepIntervalRst;
      backlash_steps_q <= dcmp_pkg::BacklashStepsRst;
      backlash_en_q    <= dcmp_pkg::BacklashEnRst;
      speed_q          <= dcmp_pkg::SpeedRst;
    end else if (cfg_wr) begin
      case (reg_sel)
        dcmp_pkg::REG_STEP_INTERVAL:  step_interval_q  <= pwdata[15:0];
        dcmp_pkg::REG_BACKLASH_STEPS: backlash_steps_q <= pwdata[15:0];
        dcmp_pkg::REG_BACKLASH_EN:    backlash_en_q    <= pwdata[0];
        dcmp_pkg::REG_SPEED:          speed_q          <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // datapath
  assign in_i.ready = !skid_v_q;
  assign accept     = in_i.valid && in_i.ready;
  assign out_take   = out_v_q && out_o.ready;
  assign val_wide   = WideBits'(in_i.value);
  assign el_inc     = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign ccw        = !(tgt_q > cur_q);

  always_comb begin
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    last_ccw_d = last_ccw_q;
    elapsed_d  = elapsed_q;
    bl_left_d  = bl_left_q;
    bridge_d   = bridge_q;
    duty_d     = duty_q;
    do_step    = 1'b0;
    stepped    = 1'b0;
    case (dcmp_pkg::mode_e'(in_i.mode))
      dcmp_pkg::MODE_TARGET:  tgt_d = val_wide[POSITION_BITS-1:0];
      dcmp_pkg::MODE_CURRENT: cur_d = val_wide[POSITION_BITS-1:0];
      dcmp_pkg::MODE_TICK: begin
        elapsed_d = el_inc;
        if (cur_q == tgt_q) begin
          last_ccw_d = 1'b1;
          bl_left_d  = 16'd0;
        end else if (el_inc >= step_interval_q) begin
          elapsed_d = 16'd0;
          if (ccw != last_ccw_q) begin
            last_ccw_d = ccw;
            if (backlash_en_q && (backlash_steps_q != 16'd0)) begin
              bridge_d  = ccw ? 3'b110 : 3'b101;
              duty_d    = speed_q;
              bl_left_d = backlash_steps_q;
            end else begin
              bl_left_d = 16'd0;
              do_step   = 1'b1;
            end
          end else if (bl_left_q != 16'd0) begin
            bridge_d  = ccw ? 3'b110 : 3'b101;
            duty_d    = speed_q;
            bl_left_d = bl_left_q - 16'd1;
            do_step   = (bl_left_q == 16'd1);
          end else begin
            do_step = 1'b1;
          end
          if (do_step) begin
            bridge_d = ccw ? 3'b110 : 3'b101;
            duty_d   = speed_q;
            cur_d    = ccw ? cur_q - POSITION_BITS'(1) : cur_q + POSITION_BITS'(1);
            stepped  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign pos_wide = WideBits'(cur_d);

  always_comb begin
    res.drive_a      = bridge_d[0];
    res.drive_b      = bridge_d[1];
    res.drive_on     = bridge_d[2];
    res.duty         = duty_d;
    res.position     = pos_wide[31:0];
    res.stepped      = stepped;
    res.compensating = (bl_left_d != 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      tgt_q      <= '0;
      last_ccw_q <= 1'b0;
      elapsed_q  <= 16'd0;
      bl_left_q  <= 16'd0;
      bridge_q   <= 3'b000;
      duty_q     <= 8'd0;
    end else if (accept) begin
      cur_q      <= cur_d;
      tgt_q      <= tgt_d;
      last_ccw_q <= last_ccw_d;
      elapsed_q  <= elapsed_d;
      bl_left_q  <= bl_left_d;
      bridge_q   <= bridge_d;
      duty_q     <= duty_d;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= accept;
      end
    end else if (accept) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_take) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.drive_a      = out_q.drive_a;
  assign out_o.drive_b      = out_q.drive_b;
  assign out_o.drive_on     = out_q.drive_on;
  assign out_o.duty         = out_q.duty;
  assign out_o.position     = out_q.position;
  assign out_o.stepped      = out_q.stepped;
  assign out_o.compensating = out_q.compensating;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid word without output word");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_v_q) else $error("accepted word not presented");

  a_bridge_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bridge_q[0] && bridge_q[1])) else $error("both bridge legs driven");

  a_step_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.stepped || out_q.compensating)) |-> out_q.drive_on)
    else $error("step or take-up without drive enable");

  a_comp_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bl_left_q != 16'd0) |-> bridge_q[2]) else $error("take-up while bridge idle");

endmodule

### verif/motor_step_checker.sv
`timescale 1ns / 100ps

module motor_step_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dcmp_in_if                            in_mon,
  dcmp_out_if                           out_mon,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcmp_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            mismatches_o,
  output int                            pending_o
);

  logic [15:0]        step_interval;
  logic [15:0]        backlash_steps;
  logic               backlash_en;
  logic [7:0]         speed;

  logic signed [31:0] cur_pos;
  logic signed [31:0] target_pos;
  logic               last_ccw;
  logic [15:0]        elapsed;
  logic [15:0]        slack_left;
  logic [2:0]         levels;
  logic [7:0]         duty_lat;

  dcmp_pkg::res_t     pending_results[$];
  int                 mismatches;

  task automatic flag_field(input string field, input logic [31:0] got,
                            input logic [31:0] want);
    $display("%0t ns: %s got %0h want %0h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic apply_drive(input logic ccw);
    levels   = ccw ? 3'b110 : 3'b101;
    duty_lat = speed;
  endtask

  task automatic advance_motor(input dcmp_pkg::mode_e mode,
                               input logic signed [31:0] value,
                               output dcmp_pkg::res_t r);
    logic ccw;
    logic step_now;
    logic stepped;
    stepped  = 1'b0;
    step_now = 1'b0;
    case (mode)
      dcmp_pkg::MODE_TARGET:  target_pos = value;
      dcmp_pkg::MODE_CURRENT: cur_pos = value;
      dcmp_pkg::MODE_TICK: begin
        if (elapsed != 16'hFFFF) elapsed++;
        if (cur_pos == target_pos) begin
          last_ccw   = 1'b1;
          slack_left = '0;
        end else if (elapsed >= step_interval) begin
          ccw     = !(target_pos > cur_pos);
          elapsed = '0;
          if (ccw != last_ccw) begin
            last_ccw = ccw;
            if (backlash_en && backlash_steps != 0) begin
              apply_drive(ccw);
              slack_left = backlash_steps;
            end else begin
              slack_left = '0;
              step_now   = 1'b1;
            end
          end else if (slack_left != 0) begin
            apply_drive(ccw);
            slack_left--;
            if (slack_left == 0) step_now = 1'b1;
          end else begin
            step_now = 1'b1;
          end
          if (step_now) begin
            apply_drive(ccw);
            cur_pos = ccw ? cur_pos - 32'sd1 : cur_pos + 32'sd1;
            stepped = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.drive_a      = levels[0];
    r.drive_b      = levels[1];
    r.drive_on     = levels[2];
    r.duty         = duty_lat;
    r.position     = cur_pos;
    r.stepped      = stepped;
    r.compensating = (slack_left != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dcmp_pkg::res_t r;
    dcmp_pkg::res_t want;
    if (!rst_ni) begin
      step_interval  = dcmp_pkg::StepIntervalRst;
      backlash_steps = dcmp_pkg::BacklashStepsRst;
      backlash_en    = dcmp_pkg::BacklashEnRst;
      speed          = dcmp_pkg::SpeedRst;
      cur_pos        = '0;
      target_pos     = '0;
      last_ccw       = 1'b0;
      elapsed        = '0;
      slack_left     = '0;
      levels         = '0;
      duty_lat       = '0;
      pending_results.delete();
      mismatches     = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (dcmp_pkg::reg_e'(paddr[3:2]))
          dcmp_pkg::REG_STEP_INTERVAL:  step_interval  = pwdata[15:0];
          dcmp_pkg::REG_BACKLASH_STEPS: backlash_steps = pwdata[15:0];
          dcmp_pkg::REG_BACKLASH_EN:    backlash_en    = pwdata[0];
          dcmp_pkg::REG_SPEED:          speed          = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          flag_field("unexpected word, position", out_mon.position, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_mon.drive_a !== want.drive_a)
            flag_field("drive_a", 32'(out_mon.drive_a), 32'(want.drive_a));
          if (out_mon.drive_b !== want.drive_b)
            flag_field("drive_b", 32'(out_mon.drive_b), 32'(want.drive_b));
          if (out_mon.drive_on !== want.drive_on)
            flag_field("drive_on", 32'(out_mon.drive_on), 32'(want.drive_on));
          if (out_mon.duty !== want.duty)
            flag_field("duty", 32'(out_mon.duty), 32'(want.duty));
          if (out_mon.position !== want.position)
            flag_field("position", out_mon.position, want.position);
          if (out_mon.stepped !== want.stepped)
            flag_field("stepped", 32'(out_mon.stepped), 32'(want.stepped));
          if (out_mon.compensating !== want.compensating)
            flag_field("compensating", 32'(out_mon.compensating),
                       32'(want.compensating));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        advance_motor(dcmp_pkg::mode_e'(in_mon.mode), in_mon.value, r);
        pending_results.push_back(r);
      end
    end
    mismatches_o = mismatches;
    pending_o    = pending_results.size();
  end

endmodule

### verif/dc_motor_position_stepper_backlash_tb.sv
`timescale 1ns / 100ps

module dc_motor_position_stepper_backlash_tb;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [dcmp_pkg::AddrBits-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  int                            mismatches;
  int                            pending;
  bit                            calm;

  dcmp_in_if  word_in ();
  dcmp_out_if word_out ();

  dc_motor_position_stepper_backlash dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (word_in),
    .out_o   (word_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  motor_step_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (word_in),
    .out_mon      (word_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    word_out.ready <= calm || ($urandom_range(0, 99) >= 13);
  end

  task automatic write_reg(input dcmp_pkg::reg_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dcmp_pkg::AddrBits'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] si, input logic [15:0] bs,
                              input logic en, input logic [7:0] sp);
    logic [31:0] w;
    w = $urandom();
    w[15:0] = si;
    write_reg(dcmp_pkg::REG_STEP_INTERVAL, w);
    w = $urandom();
    w[15:0] = bs;
    write_reg(dcmp_pkg::REG_BACKLASH_STEPS, w);
    w = $urandom();
    w[0] = en;
    write_reg(dcmp_pkg::REG_BACKLASH_EN, w);
    w = $urandom();
    w[7:0] = sp;
    write_reg(dcmp_pkg::REG_SPEED, w);
  endtask

  task automatic send_word(input dcmp_pkg::mode_e m, input logic [31:0] v);
    while (!calm && $urandom_range(0, 99) < 13) begin
      word_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_in.valid <= 1'b1;
    word_in.mode  <= m;
    word_in.value <= v;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
  endtask

  // drain every outstanding word, then let the output stage go quiet
  task automatic settle();
    word_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int          counted;
    int          phase;
    int          len;
    int          r;
    logic [15:0] si;
    logic [15:0] bs;
    logic [7:0]  sp;
    logic [31:0] base;

    calm           = 1'b0;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    word_in.valid  <= 1'b0;
    word_in.mode   <= dcmp_pkg::MODE_TICK;
    word_in.value  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values in force
    send_word(dcmp_pkg::MODE_TARGET, 32'd5);
    send_word(dcmp_pkg::MODE_TICK, 32'hFFFF_FFFF);
    send_word(dcmp_pkg::MODE_TICK, 32'h0);
    settle();

    // position extremes, take-up on reversal, unused mode
    program_regs(16'd1, 16'd2, 1'b1, 8'd0);
    send_word(dcmp_pkg::MODE_NONE, 32'hFFFF_FFFF);
    send_word(dcmp_pkg::MODE_CURRENT, 32'h7FFF_FFFF);
    send_word(dcmp_pkg::MODE_TARGET, 32'h8000_0000);
    repeat (3) send_word(dcmp_pkg::MODE_TICK, $urandom());
    send_word(dcmp_pkg::MODE_TARGET, 32'h7FFF_FFFF);
    repeat (5) send_word(dcmp_pkg::MODE_TICK, $urandom());
    send_word(dcmp_pkg::MODE_NONE, 32'h0);
    settle();

    // zero interval, compensation off
    program_regs(16'd0, 16'd0, 1'b0, 8'd255);
    send_word(dcmp_pkg::MODE_CURRENT, 32'hFFFF_FFFE);
    send_word(dcmp_pkg::MODE_TARGET, 32'd1);
    repeat (4) send_word(dcmp_pkg::MODE_TICK, $urandom());
    send_word(dcmp_pkg::MODE_TARGET, 32'hFFFF_FFFD);
    repeat (4) send_word(dcmp_pkg::MODE_TICK, $urandom());
    settle();

    // longest interval while parked on target
    program_regs(16'hFFFF, 16'hFFFF, 1'b1, 8'd128);
    send_word(dcmp_pkg::MODE_CURRENT, 32'd100);
    send_word(dcmp_pkg::MODE_TARGET, 32'd100);
    repeat (20) send_word(dcmp_pkg::MODE_TICK, $urandom());
    send_word(dcmp_pkg::MODE_TARGET, 32'd101);
    repeat (3) send_word(dcmp_pkg::MODE_TICK, $urandom());
    settle();

    counted = 0;
    phase   = 0;
    while (counted < 1550) begin
      settle();
      calm = (phase >= 6 && phase < 9);
      r = $urandom_range(0, 19);
      si = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 4));
      r = $urandom_range(0, 9);
      bs = (r < 2) ? 16'd0 : (r == 2) ? 16'hFFFF : 16'($urandom_range(1, 3));
      r = $urandom_range(0, 19);
      sp = (r < 3) ? 8'd0 : (r < 6) ? 8'd255 : 8'($urandom());
      program_regs(si, bs, 1'($urandom()), sp);
      r = $urandom_range(0, 9);
      base = (r == 0) ? 32'h7FFF_FFE0 : (r == 1) ? 32'h8000_0010 : $urandom();
      send_word(dcmp_pkg::MODE_CURRENT, base);
      send_word(dcmp_pkg::MODE_TARGET, base + 32'($urandom_range(0, 24)) - 32'd12);
      counted += 2;
      len = $urandom_range(40, 120);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          send_word(dcmp_pkg::MODE_TARGET, base + 32'($urandom_range(0, 24)) - 32'd12);
          counted++;
        end else if (r < 8) begin
          send_word(dcmp_pkg::MODE_CURRENT, base + 32'($urandom_range(0, 24)) - 32'd12);
          counted++;
        end else if (r < 10) begin
          send_word(dcmp_pkg::MODE_TARGET, $urandom());
          counted++;
        end else if (r < 12) begin
          send_word(dcmp_pkg::MODE_NONE, $urandom());
        end else begin
          send_word(dcmp_pkg::MODE_TICK, $urandom());
          counted++;
        end
      end
      phase++;
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
